// ===== design/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and codes for the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int ValueW  = 32;
  localparam int ColW    = 3;
  localparam int ModeW   = 2;
  localparam int StatusW = 2;
  localparam int CountW  = 9;
  localparam int MaxCols = 4;

  localparam logic [ModeW-1:0] MODE_APPEND = 2'd0;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 2'd1;
  localparam logic [ModeW-1:0] MODE_INTERP = 2'd2;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL   = 2'd2;
  localparam logic [StatusW-1:0] ST_BADCOL = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RDL,
    S_CHKL,
    S_SRCH_A,
    S_SRCH_B,
    S_FETCH,
    S_END,
    S_GETL,
    S_GETH,
    S_PREP,
    S_DIV,
    S_MUL,
    S_ADD,
    S_DONE
  } tli_state_t;

endpackage

// ===== design/tli_if.sv =====
// ----------------------------------------------------------------------------
// tli_if
// Valid/ready channels carrying query items in and results out.
// ----------------------------------------------------------------------------
interface tli_in_if import tli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ModeW-1:0]         mode;
  logic signed [ValueW-1:0] abscissa;
  logic signed [ValueW-1:0] ord_a;
  logic signed [ValueW-1:0] ord_b;
  logic signed [ValueW-1:0] ord_c;
  logic signed [ValueW-1:0] ord_d;
  logic [ColW-1:0]          column;

  modport source (output valid, mode, abscissa, ord_a, ord_b, ord_c, ord_d, column,
                  input ready);
  modport sink   (input valid, mode, abscissa, ord_a, ord_b, ord_c, ord_d, column,
                  output ready);
endinterface

interface tli_out_if import tli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] result_value;
  logic [StatusW-1:0]       status;
  logic [CountW-1:0]        row_count;

  modport source (output valid, result_value, status, row_count, input ready);
  modport sink   (input valid, result_value, status, row_count, output ready);
endinterface

// ===== design/table_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear interpolation over a table of Q16.16 rows.
// ----------------------------------------------------------------------------
// Items arrive on in_ch and each gives exactly one transaction on out_ch.
// Mode append stores a row (abscissa plus the ordinate columns), mode clear
// empties the table and mode interpolate returns the value of one column at
// the query abscissa, clamped at both table ends.
// One item is in flight at a time; in_ch.ready is high only when the
// sequencer is idle. Append, clear and error answers are set in S_EXEC
// and pass through S_DONE to the output register. An interpolation reads the
// abscissa memory once per probe of a binary search (about log2(rows)+1
// probes), then runs a 17-step restoring divider for the weight and one
// 18x33 multiply. Answers clamped at the table ends skip the divider.
// The result sits in an output register; if out_ch stalls the sequencer
// waits with the finished result and takes no new item until it leaves.
// Synchronous reset empties the table and drops any pending result. The
// memories need no clearing pass: entries are read only below the row count.
// ----------------------------------------------------------------------------
module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int NUM_COLS = 4
) (
  input logic      clk,
  input logic      rst,
  tli_in_if.sink   in_ch,
  tli_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = NUM_COLS * ValueW;

  tli_state_t state, state_next;

  // Latched item.
  logic [ModeW-1:0]         mode_r;
  logic signed [ValueW-1:0] t_r;
  logic [ColW-1:0]          col_r;
  logic [MaxCols*ValueW-1:0] ords_r;

  logic [CW-1:0] rows_held;
  logic [CW-1:0] lo, hi;
  logic [CW-1:0] mid, nm1;

  logic signed [ValueW-1:0] xl, yl;
  logic signed [32:0]       dx, num, dy;
  logic [32:0]              rem;
  logic [16:0]              quo;
  logic [4:0]               cnt;
  logic signed [50:0]       prod;

  logic signed [ValueW-1:0] res_value;
  logic [StatusW-1:0]       res_status;
  logic                     out_valid;
  logic signed [ValueW-1:0] out_value;
  logic [StatusW-1:0]       out_status;
  logic [CountW-1:0]        out_count;

  logic              we;
  logic [AW-1:0]     raddr;
  logic [ValueW-1:0] rdx;
  logic [RW-1:0]     rdy;
  logic signed [ValueW-1:0] sel_val;
  logic              out_free;
  logic [33:0]       trial, dx_ext;
  logic              ge;
  logic signed [50:0] prod_adj;
  logic [CW+CountW-1:0] count_ext;

  assign mid = lo + ((hi - lo) >> 1);
  assign nm1 = rows_held - CW'(1);
  assign we  = (state == S_EXEC) && (mode_r == MODE_APPEND) && (rows_held != CW'(DEPTH));
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  tli_ram #(.WIDTH(ValueW), .DEPTH(DEPTH)) u_xram (
    .clk(clk), .we(we), .waddr(rows_held[AW-1:0]), .wdata(t_r),
    .raddr(raddr), .rdata(rdx)
  );

  tli_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_yram (
    .clk(clk), .we(we), .waddr(rows_held[AW-1:0]), .wdata(ords_r[RW-1:0]),
    .raddr(raddr), .rdata(rdy)
  );

  // Column 0 is the abscissa itself.
  always_comb begin
    sel_val = rdy[ValueW-1:0];
    for (int c = 1; c < NUM_COLS; c++) begin
      if (col_r == ColW'(c + 1)) begin
        sel_val = rdy[c*ValueW +: ValueW];
      end
    end
    if (col_r == '0) begin
      sel_val = rdx;
    end
  end

  always_comb begin
    unique case (state)
      S_RDL:    raddr = nm1[AW-1:0];
      S_SRCH_A: raddr = mid[AW-1:0];
      S_FETCH: begin
        if (hi == '0) begin
          raddr = '0;
        end else if (hi >= rows_held) begin
          raddr = nm1[AW-1:0];
        end else begin
          raddr = AW'(hi - CW'(1));
        end
      end
      S_GETL:   raddr = hi[AW-1:0];
      default:  raddr = '0;
    endcase
  end

  assign dx_ext   = {1'b0, dx};
  assign trial    = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign ge       = trial >= dx_ext;
  assign prod_adj = prod + (prod[50] ? 51'sd65535 : 51'sd0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_ch.valid) state_next = S_EXEC;
      S_EXEC: begin
        if (mode_r == MODE_INTERP && col_r <= ColW'(NUM_COLS) && rows_held != '0) begin
          state_next = S_RDL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RDL: begin
        if (rows_held == CW'(1) || t_r <= $signed(rdx)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CHKL;
        end
      end
      S_CHKL:   state_next = (t_r >= $signed(rdx)) ? S_DONE : S_SRCH_A;
      S_SRCH_A: state_next = (lo < hi) ? S_SRCH_B : S_FETCH;
      S_SRCH_B: state_next = S_SRCH_A;
      S_FETCH:  state_next = (hi == '0 || hi >= rows_held) ? S_END : S_GETL;
      S_END:    state_next = S_DONE;
      S_GETL:   state_next = S_GETH;
      S_GETH:   state_next = S_PREP;
      S_PREP:   state_next = (dx <= 33'sd0) ? S_DONE : S_DIV;
      S_DIV:    if (cnt == 5'd16) state_next = S_MUL;
      S_MUL:    state_next = S_ADD;
      S_ADD:    state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_held <= '0;
    end else if (state == S_EXEC) begin
      if (we) begin
        rows_held <= rows_held + CW'(1);
      end else if (mode_r == MODE_CLEAR) begin
        rows_held <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mode_r <= in_ch.mode;
        t_r    <= in_ch.abscissa;
        col_r  <= in_ch.column;
        ords_r <= {in_ch.ord_d, in_ch.ord_c, in_ch.ord_b, in_ch.ord_a};
      end
      S_EXEC: begin
        res_value  <= '0;
        res_status <= ST_OK;
        if (mode_r == MODE_APPEND && rows_held == CW'(DEPTH)) begin
          res_status <= ST_FULL;
        end else if (mode_r == MODE_INTERP) begin
          if (col_r > ColW'(NUM_COLS)) begin
            res_status <= ST_BADCOL;
          end else if (rows_held == '0) begin
            res_status <= ST_EMPTY;
          end
        end
      end
      S_RDL:  res_value <= sel_val;
      S_CHKL: begin
        res_value <= sel_val;
        lo <= '0;
        hi <= rows_held;
      end
      S_SRCH_B: begin
        if ($signed(rdx) < t_r) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      S_END:  res_value <= sel_val;
      S_GETL: begin
        xl <= rdx;
        yl <= sel_val;
      end
      S_GETH: begin
        dx  <= 33'($signed(rdx)) - 33'(xl);
        num <= 33'(t_r) - 33'(xl);
        dy  <= 33'(sel_val) - 33'(yl);
      end
      S_PREP: begin
        res_value <= yl;
        cnt <= '0;
        quo <= '0;
        // The offset into the interval is clamped into 0..dx.
        if (num < 33'sd0) begin
          rem <= '0;
        end else if (num > dx) begin
          rem <= dx;
        end else begin
          rem <= num;
        end
      end
      S_DIV: begin
        rem <= ge ? 33'(trial - dx_ext) : trial[32:0];
        quo <= {quo[15:0], ge};
        cnt <= cnt + 5'd1;
      end
      S_MUL:  prod <= $signed({34'b0, quo}) * $signed({{18{dy[32]}}, dy});
      S_ADD:  res_value <= yl + prod_adj[47:16];
      default: ;
    endcase
  end

  assign count_ext = {{CountW{1'b0}}, rows_held};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_count  <= count_ext[CountW-1:0];
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result_value = out_value;
  assign out_ch.status       = out_status;
  assign out_ch.row_count    = out_count;

  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    rows_held <= CW'(DEPTH))
    else $error("row count exceeds table depth");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH_A |-> (lo <= hi && hi <= rows_held))
    else $error("binary search bounds out of order");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt <= 5'd16)
    else $error("divider ran past its last step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

endmodule

// ===== design/tli_ram.sv =====
// ----------------------------------------------------------------------------
// tli_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/tli_checker.sv =====
// ----------------------------------------------------------------------------
// tli_checker
// Watches both channels of the table linear interpolator, predicts each
// result from a private copy of the table and compares field by field.
// ----------------------------------------------------------------------------
module tli_checker
  import tli_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int NUM_COLS = 4
) (
  input  logic    clk,
  input  logic    rst,
  tli_in_if.sink  in_mon,
  tli_out_if.sink out_mon,
  output int      errors,
  output int      pending
);

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [StatusW-1:0]       status;
    logic [CountW-1:0]        count;
  } answer_t;

  logic signed [ValueW-1:0] xs [DEPTH];
  logic signed [ValueW-1:0] ys [DEPTH][NUM_COLS];
  int unsigned              rows;
  answer_t                  answers_due[$];

  assign pending = answers_due.size();

  function automatic logic signed [ValueW-1:0] cell_of(int unsigned r, int unsigned c);
    return (c == 0) ? xs[r] : ys[r][c-1];
  endfunction

  function automatic logic signed [ValueW-1:0] lookup(logic signed [ValueW-1:0] t,
                                                      int unsigned c);
    int unsigned lo, hi, mid;
    longint dx, num, dy, w, prod;
    logic signed [ValueW-1:0] yl;
    if (rows == 1 || t <= xs[0]) return cell_of(0, c);
    if (t >= xs[rows-1]) return cell_of(rows-1, c);
    lo = 0;
    hi = rows;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (xs[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    if (hi == 0) return cell_of(0, c);
    if (hi >= rows) return cell_of(rows-1, c);
    lo = hi - 1;
    yl = cell_of(lo, c);
    dx = longint'(xs[hi]) - longint'(xs[lo]);
    if (dx <= 0) return yl;
    num = longint'(t) - longint'(xs[lo]);
    if (num < 0) num = 0;
    if (num > dx) num = dx;
    w = (num <<< 16) / dx;
    dy = longint'(cell_of(hi, c)) - longint'(yl);
    prod = w * dy;
    // SystemVerilog division truncates towards zero, as required here.
    return ValueW'(longint'(yl) + prod / 65536);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    answer_t a, w;
    if (rst) begin
      rows = 0;
      errors = 0;
      answers_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        a = '0;
        case (in_mon.mode)
          MODE_APPEND: begin
            if (rows >= DEPTH) a.status = ST_FULL;
            else begin
              xs[rows] = in_mon.abscissa;
              ys[rows][0] = in_mon.ord_a;
              if (NUM_COLS > 1) ys[rows][1] = in_mon.ord_b;
              if (NUM_COLS > 2) ys[rows][2] = in_mon.ord_c;
              if (NUM_COLS > 3) ys[rows][3] = in_mon.ord_d;
              rows++;
            end
          end
          MODE_CLEAR: rows = 0;
          MODE_INTERP: begin
            if (in_mon.column > NUM_COLS) a.status = ST_BADCOL;
            else if (rows == 0) a.status = ST_EMPTY;
            else a.value = lookup(in_mon.abscissa, in_mon.column);
          end
          default: ;
        endcase
        a.count = rows[CountW-1:0];
        answers_due = {answers_due, a};
      end
      if (out_mon.valid && out_mon.ready) begin
        if (answers_due.size() == 0) report("unexpected result", 0, 0);
        else begin
          w = answers_due.pop_front();
          if (out_mon.result_value !== w.value)
            report("result_value", out_mon.result_value, w.value);
          if (out_mon.status !== w.status) report("status", out_mon.status, w.status);
          if (out_mon.row_count !== w.count)
            report("row_count", out_mon.row_count, w.count);
        end
      end
    end
  end

endmodule

// ===== test/table_linear_interpolator_tb.sv =====
// ----------------------------------------------------------------------------
// table_linear_interpolator_tb
// Drives append, clear, interpolate and unused-mode transactions with random idling on
// both channels; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module table_linear_interpolator_tb;
  import tli_pkg::*;

  localparam int Depth   = 256;
  localparam int Limit   = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   send_idle, recv_idle;
  int   quiet;

  tli_in_if  in_ch ();
  tli_out_if out_ch ();

  table_linear_interpolator #(.DEPTH(Depth), .NUM_COLS(MaxCols)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  tli_checker #(.DEPTH(Depth), .NUM_COLS(MaxCols)) checker_i (
    .clk(clk), .rst(rst), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_CLEAR;
    in_ch.abscissa = '0;
    in_ch.ord_a = '0;
    in_ch.ord_b = '0;
    in_ch.ord_c = '0;
    in_ch.ord_d = '0;
    in_ch.column = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= Limit) begin
      $display("table_linear_interpolator: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // Valid stays high from one transaction to the next unless the sender idles.
  task automatic send(logic [ModeW-1:0] m, logic [31:0] x, logic [31:0] a,
                      logic [31:0] b, logic [31:0] c, logic [31:0] d,
                      logic [ColW-1:0] col);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.abscissa <= x;
    in_ch.ord_a <= a;
    in_ch.ord_b <= b;
    in_ch.ord_c <= c;
    in_ch.ord_d <= d;
    in_ch.column <= col;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic append(logic [31:0] x);
    send(MODE_APPEND, x, rand_word(), rand_word(), rand_word(), rand_word(),
         ColW'($urandom));
  endtask

  task automatic query(logic [31:0] x);
    send(MODE_INTERP, x, $urandom, $urandom, $urandom, $urandom,
         ($urandom_range(9) == 0) ? ColW'($urandom_range(7)) : ColW'($urandom_range(MaxCols)));
  endtask

  // A table of random size with mostly rising abscissas, then queries into it.
  task automatic random_phase(int items);
    int done, n;
    logic signed [31:0] x;
    done = 0;
    while (done < items) begin
      send(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, ColW'($urandom));
      n = ($urandom_range(9) == 0) ? $urandom_range(Depth + 3) : $urandom_range(1, 12);
      x = -$signed(32'($urandom_range(1 << 20)));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0) append(rand_word());
        else append(x);
        x = x + $urandom_range(($urandom_range(7) == 0) ? 0 : 1, 1 << 18);
      end
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(3) == 0) query(rand_word());
        else query(x - $urandom_range(n * (1 << 18) + 1000));
        if ($urandom_range(30) == 0)
          send(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
               ColW'($urandom));
      end
      done += n + 13;
    end
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, bad column, one row, clamping, flat interval.
    send(MODE_INTERP, 0, 0, 0, 0, 0, 3'd1);
    send(MODE_INTERP, 0, 0, 0, 0, 0, 3'd7);
    send(MODE_APPEND, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 5, 3'd0);
    send(MODE_INTERP, 32'h8000_0000, 0, 0, 0, 0, 3'd2);
    send(MODE_APPEND, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h1234_5678, 3'd0);
    send(MODE_APPEND, 32'h0003_0000, 1, 2, 3, 4, 3'd0);
    send(MODE_APPEND, 32'h7fff_ffff, 9, 9, 9, 9, 3'd0);
    for (int c = 0; c <= 5; c++) send(MODE_INTERP, 32'h0002_0000, 0, 0, 0, 0, ColW'(c));
    send(MODE_INTERP, 32'h0001_8000, 0, 0, 0, 0, 3'd1);
    send(MODE_INTERP, 32'h0003_0000, 0, 0, 0, 0, 3'd3);
    send(MODE_INTERP, 32'h7fff_ffff, 0, 0, 0, 0, 3'd4);
    send(MODE_INTERP, 32'h0001_0000, 0, 0, 0, 0, 3'd0);
    send(MODE_APPEND, 32'h0000_0000, 7, 7, 7, 7, 3'd0);  // falling abscissa
    send(MODE_INTERP, 32'h4000_0000, 0, 0, 0, 0, 3'd1);
    send(MODE_UNUSED, 32'hffff_ffff, 0, 0, 0, 0, 3'd7);
    // Fill to capacity; the last five of these appends are dropped.
    for (int i = 0; i < Depth; i++) append(i << 8);
    send(MODE_INTERP, 32'h0000_7f80, 0, 0, 0, 0, 3'd2);

    send_idle = 12;
    recv_idle = 46;
    random_phase(540);
    send_idle = 46;
    recv_idle = 12;
    random_phase(540);
    send_idle = 0;
    recv_idle = 0;
    random_phase(540);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("table_linear_interpolator: match");
    else $display("table_linear_interpolator: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tli_pkg.sv
design/tli_if.sv
design/tli_ram.sv
design/table_linear_interpolator.sv
test/tli_checker.sv
test/table_linear_interpolator_tb.sv
